// ----- hdl/mslbs_pkg.sv -----
// package for the multi-slot bounded list store
// command and status codes, controller states, control structs; no dependencies
`timescale 1ns / 1ps
package mslbs_pkg;

    localparam int NUM_SLOTS_DEF = 10;
    localparam int MAX_CAP_DEF   = 15;

    typedef enum logic [2:0] {
        F_CREATE = 3'd0,
        F_APPEND = 3'd1,
        F_POP    = 3'd2,
        F_DELETE = 3'd3,
        F_READ   = 3'd4,
        F_SORTED = 3'd5,
        F_GROW   = 3'd6,
        F_COUNT  = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_BAD_SLOT  = 4'd1,
        ST_EXISTS    = 4'd2,
        ST_NO_ROOM   = 4'd3,
        ST_BAD_SIZE  = 4'd4,
        ST_FULL      = 4'd5,
        ST_NONE      = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_NOT_FOUND = 4'd8,
        ST_BAD_INC   = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        K_IMM,
        K_DEL,
        K_READ,
        K_SORT
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RD_RD,
        S_RD_CAP,
        S_SRT_RD,
        S_SRT_CMP,
        S_SRT_EMIT,
        S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic decide;
        logic rd_next;
        logic del_step;
        logic del_hit;
        logic del_miss;
        logic shift_wr;
        logic del_done;
        logic cap_read;
        logic scan_cmp;
        logic emit_sorted;
        logic next_out;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  match;
        logic  scan_end;
        logic  shift_end;
        logic  out_taken;
        logic  more;
    } t_stat;

endpackage

// ----- hdl/multi_slot_bounded_list_store.sv -----
// top level of the multi-slot bounded list store: ten bounded lists of signed words
// depends on mslbs_pkg, mslbs_ctrl, mslbs_dp (which holds mslbs_ram)
// one item at a time: ready only when idle with the previous result delivered
// simple commands: the item is latched, then the result is registered in the decode state
// delete: a read and a compare state per element searched, a read and a write state per element shifted
// read: read, capture, output wait per element; sorted read: a full scan of the list per element
// synchronous active-low reset clears slot tables and control; element ram is not cleared
`timescale 1ns / 1ps
module multi_slot_bounded_list_store #(
    parameter int NUM_SLOTS = mslbs_pkg::NUM_SLOTS_DEF,
    parameter int MAX_CAP   = mslbs_pkg::MAX_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_slot,
    input  logic signed [5:0]  i_size_arg,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_status,
    output logic signed [31:0] o_data_value,
    output logic [3:0]         o_element_count,
    output logic               o_last
);
    import mslbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mslbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mslbs_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_CAP   (MAX_CAP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .i_size_arg      (i_size_arg),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_data_value    (o_data_value),
        .o_element_count (o_element_count),
        .o_last          (o_last)
    );
endmodule

// ----- hdl/mslbs_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module mslbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 150,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/mslbs_ctrl.sv -----
// controller state machine for the list store
// depends on mslbs_pkg; drives datapath commands from datapath status
`timescale 1ns / 1ps
module mslbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mslbs_pkg::t_stat i_stat,
    output mslbs_pkg::t_cmd  o_cmd
);
    import mslbs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decide = 1'b1;
                unique case (i_stat.kind)
                    K_IMM:   n_state = S_OUT_WAIT;
                    K_DEL:   n_state = S_DEL_RD;
                    K_READ:  n_state = S_RD_RD;
                    default: n_state = S_SRT_RD;
                endcase
            end
            S_DEL_RD: n_state = S_DEL_CMP;
            S_DEL_CMP: begin
                if (i_stat.match) begin
                    o_cmd.del_hit = 1'b1;
                    n_state       = S_SH_RD;
                end else if (i_stat.scan_end) begin
                    o_cmd.del_miss = 1'b1;
                    n_state        = S_OUT_WAIT;
                end else begin
                    o_cmd.del_step = 1'b1;
                    n_state        = S_DEL_RD;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_next = 1'b1;
                if (i_stat.shift_end) begin
                    o_cmd.del_done = 1'b1;
                    n_state        = S_OUT_WAIT;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SH_RD;
            end
            S_RD_RD: n_state = S_RD_CAP;
            S_RD_CAP: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_OUT_WAIT;
            end
            S_SRT_RD: n_state = S_SRT_CMP;
            S_SRT_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_stat.scan_end ? S_SRT_EMIT : S_SRT_RD;
            end
            S_SRT_EMIT: begin
                o_cmd.emit_sorted = 1'b1;
                n_state           = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.more) begin
                        o_cmd.next_out = 1'b1;
                        n_state        = (i_stat.kind == K_SORT) ? S_SRT_RD : S_RD_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_load_decodes;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE);
    endproperty
    a_load_decodes: assert property (p_load_decodes)
        else $error("accepted item did not enter decode");

    property p_taken_last_idles;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_OUT_WAIT && i_stat.out_taken && !i_stat.more)
                |=> (r_state == S_IDLE);
    endproperty
    a_taken_last_idles: assert property (p_taken_last_idles)
        else $error("final result taken but controller not idle");

    property p_hit_shifts;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DEL_CMP && i_stat.match) |=> (r_state == S_SH_RD);
    endproperty
    a_hit_shifts: assert property (p_hit_shifts)
        else $error("delete match did not start shift");
endmodule

// ----- hdl/mslbs_dp.sv -----
// datapath of the list store: slot tables, element ram, scan counters, result register
// depends on mslbs_pkg and mslbs_ram
`timescale 1ns / 1ps
module mslbs_dp #(
    parameter int NUM_SLOTS = mslbs_pkg::NUM_SLOTS_DEF,
    parameter int MAX_CAP   = mslbs_pkg::MAX_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mslbs_pkg::t_cmd    i_cmd,
    output mslbs_pkg::t_stat   o_stat,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_slot,
    input  logic signed [5:0]  i_size_arg,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_status,
    output logic signed [31:0] o_data_value,
    output logic [3:0]         o_element_count,
    output logic               o_last
);
    import mslbs_pkg::*;

    localparam int SIW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW    = $clog2(MAX_CAP + 1);
    localparam int DEPTH = NUM_SLOTS * MAX_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // latched item
    t_func              r_func;
    logic               r_slot_ok;
    logic [SIW-1:0]     r_sidx;
    logic signed [5:0]  r_size;
    logic signed [31:0] r_value;

    logic           r_present [NUM_SLOTS];
    logic [CW-1:0]  r_cap     [NUM_SLOTS];
    logic [CW-1:0]  r_fill    [NUM_SLOTS];

    logic [CW-1:0]  r_idx, r_k;
    t_kind          r_kind;

    logic signed [31:0] r_best_val, r_prev_val;
    logic [CW-1:0]      r_best_idx, r_prev_idx;
    logic               r_best_ok, r_have_prev;

    logic               cur_present;
    logic [CW-1:0]      cur_cap, cur_fill;
    logic [AW-1:0]      base, raddr, waddr;
    logic signed [31:0] rdata, wdata;
    logic               we;

    t_status       imm_st;
    logic [CW-1:0] imm_cnt;
    t_kind         imm_kind;
    logic          upd_present, upd_cap, upd_fill;
    logic [CW-1:0] new_cap, new_fill;
    logic [7:0]    size_u, grow_cap;
    logic          gt_prev, better;

    assign cur_present = r_slot_ok ? r_present[r_sidx] : 1'b0;
    assign cur_cap     = r_slot_ok ? r_cap[r_sidx]     : '0;
    assign cur_fill    = r_slot_ok ? r_fill[r_sidx]    : '0;
    assign base        = AW'(r_sidx) * AW'(MAX_CAP);
    assign size_u      = 8'(r_size[4:0]);
    assign grow_cap    = 8'(cur_cap) + size_u;

    // result of the single-result commands, and the kind of the longer ones
    always_comb begin
        imm_st      = ST_OK;
        imm_cnt     = cur_fill;
        imm_kind    = K_IMM;
        upd_present = 1'b0;
        upd_cap     = 1'b0;
        upd_fill    = 1'b0;
        new_cap     = cur_cap;
        new_fill    = cur_fill;
        we          = 1'b0;
        if (r_func == F_GROW && r_size[5]) begin
            imm_st = ST_BAD_INC;
        end else if (!r_slot_ok) begin
            imm_st = ST_BAD_SLOT;
        end else if (r_func == F_CREATE) begin
            if (cur_present) begin
                imm_st = ST_EXISTS;
            end else if (!r_size[5] && size_u > 8'(MAX_CAP)) begin
                imm_st = ST_NO_ROOM;
            end else if (r_size[5] || r_size == 6'sd0) begin
                imm_st = ST_BAD_SIZE;
            end else begin
                upd_present = 1'b1;
                upd_cap     = 1'b1;
                upd_fill    = 1'b1;
                new_cap     = CW'(size_u);
                new_fill    = '0;
                imm_cnt     = '0;
            end
        end else if (!cur_present) begin
            imm_st = ST_NONE;
        end else begin
            case (r_func)
                F_APPEND: begin
                    if (cur_fill >= cur_cap) begin
                        imm_st = ST_FULL;
                    end else begin
                        we       = i_cmd.decide;
                        upd_fill = 1'b1;
                        new_fill = cur_fill + CW'(1);
                        imm_cnt  = new_fill;
                    end
                end
                F_POP, F_DELETE: begin
                    if (cur_fill == '0) begin
                        imm_st = ST_EMPTY;
                    end else if (r_func == F_POP) begin
                        upd_fill = 1'b1;
                        new_fill = cur_fill - CW'(1);
                        imm_cnt  = new_fill;
                    end else begin
                        imm_kind = K_DEL;
                    end
                end
                F_READ, F_SORTED: begin
                    if (cur_fill != '0) begin
                        imm_kind = (r_func == F_READ) ? K_READ : K_SORT;
                    end
                end
                F_GROW: begin
                    if (grow_cap > 8'(MAX_CAP)) begin
                        imm_st = ST_NO_ROOM;
                    end else begin
                        upd_cap = 1'b1;
                        new_cap = CW'(grow_cap);
                    end
                end
                default: ;
            endcase
        end
    end

    assign raddr = base + AW'(i_cmd.rd_next ? r_idx + CW'(1) : r_idx);
    assign waddr = i_cmd.shift_wr ? base + AW'(r_idx) : base + AW'(cur_fill);
    assign wdata = i_cmd.shift_wr ? rdata : r_value;

    mslbs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we || i_cmd.shift_wr),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // sorted order: (value, index) pairs taken in ascending order, ties by position
    assign gt_prev = !r_have_prev || (rdata > r_prev_val)
                     || (rdata == r_prev_val && r_idx > r_prev_idx);
    assign better  = !r_best_ok || (rdata < r_best_val);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= t_func'(i_func);
            r_slot_ok <= (i_slot != 4'd0) && (8'(i_slot) <= 8'(NUM_SLOTS));
            r_sidx    <= SIW'(i_slot - 4'd1);
            r_size    <= i_size_arg;
            r_value   <= i_value;
        end
        if (i_cmd.decide) begin
            r_kind      <= imm_kind;
            r_idx       <= '0;
            r_k         <= '0;
            r_best_ok   <= 1'b0;
            r_have_prev <= 1'b0;
        end
        if (i_cmd.del_step || i_cmd.shift_wr) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_cmp) begin
            if (gt_prev && better) begin
                r_best_ok  <= 1'b1;
                r_best_val <= rdata;
                r_best_idx <= r_idx;
            end
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.emit_sorted) begin
            r_have_prev <= 1'b1;
            r_prev_val  <= r_best_val;
            r_prev_idx  <= r_best_idx;
        end
        if (i_cmd.next_out) begin
            if (r_kind == K_SORT) begin
                r_k       <= r_k + CW'(1);
                r_idx     <= '0;
                r_best_ok <= 1'b0;
            end else begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_present[i] <= 1'b0;
                r_cap[i]     <= '0;
                r_fill[i]    <= '0;
            end
        end else if (r_slot_ok) begin
            if (i_cmd.decide) begin
                if (upd_present) r_present[r_sidx] <= 1'b1;
                if (upd_cap)     r_cap[r_sidx]     <= new_cap;
                if (upd_fill)    r_fill[r_sidx]    <= new_fill;
            end
            if (i_cmd.del_done) begin
                r_fill[r_sidx] <= cur_fill - CW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.decide && imm_kind != K_DEL && imm_kind != K_SORT
                     && imm_kind != K_READ) begin
            o_out_valid <= 1'b1;
        end else if (i_cmd.decide && imm_kind == K_IMM) begin
            o_out_valid <= 1'b1;
        end else if (i_cmd.del_miss || i_cmd.del_done || i_cmd.cap_read
                     || i_cmd.emit_sorted) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            o_status        <= imm_st;
            o_data_value    <= '0;
            o_element_count <= 4'(imm_cnt);
            o_last          <= 1'b1;
        end
        if (i_cmd.del_miss) begin
            o_status        <= ST_NOT_FOUND;
            o_data_value    <= '0;
            o_element_count <= 4'(cur_fill);
            o_last          <= 1'b1;
        end
        if (i_cmd.del_done) begin
            o_status        <= ST_OK;
            o_data_value    <= '0;
            o_element_count <= 4'(cur_fill - CW'(1));
            o_last          <= 1'b1;
        end
        if (i_cmd.cap_read) begin
            o_status        <= ST_OK;
            o_data_value    <= rdata;
            o_element_count <= 4'(cur_fill);
            o_last          <= (r_idx + CW'(1) == cur_fill);
        end
        if (i_cmd.emit_sorted) begin
            o_status        <= ST_OK;
            o_data_value    <= r_best_val;
            o_element_count <= 4'(cur_fill);
            o_last          <= (r_k + CW'(1) == cur_fill);
        end
    end

    assign o_stat.kind      = i_cmd.decide ? imm_kind : r_kind;
    assign o_stat.match     = (rdata == r_value);
    assign o_stat.scan_end  = (r_idx + CW'(1) == cur_fill);
    assign o_stat.shift_end = (r_idx + CW'(1) >= cur_fill);
    assign o_stat.out_taken = o_out_valid && i_out_ready;
    assign o_stat.more      = !o_last;

    property p_fill_in_cap;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_slot_ok && cur_present) |-> (cur_fill <= cur_cap);
    endproperty
    a_fill_in_cap: assert property (p_fill_in_cap)
        else $error("slot fill above its capacity");

    property p_del_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.del_done |-> (cur_fill != '0);
    endproperty
    a_del_nonempty: assert property (p_del_nonempty)
        else $error("delete finished on an empty list");

    property p_read_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.cap_read |-> (r_idx < cur_fill);
    endproperty
    a_read_in_range: assert property (p_read_in_range)
        else $error("read beyond slot fill");

    // the count of sorted items already emitted is below the fill when a sorted item is emitted
    property p_sorted_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.emit_sorted |-> (r_k < cur_fill);
    endproperty
    a_sorted_in_range: assert property (p_sorted_in_range)
        else $error("sorted read beyond slot fill");
endmodule
